// File: design/dda_line_rasterizer_assert.svh
// Assertion macros shared by the rasterizer RTL.
// Both expect clk in scope; DDALR_ASSERT also expects rst_n.
`ifndef DDA_LINE_RASTERIZER_ASSERT_SVH
`define DDA_LINE_RASTERIZER_ASSERT_SVH

// Checked only out of reset.
`define DDALR_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define DDALR_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: design/ddalr_pkg.sv
// ----------------------------------------------------------------------------
// ddalr_pkg
// Types and constants shared by the DDA line rasterizer modules.
// ----------------------------------------------------------------------------
package ddalr_pkg;

    localparam int COORD_BITS_DEF = 11;
    localparam int FRAC_BITS_DEF  = 16;

    localparam int COLOR_W = 4;
    localparam logic [COLOR_W-1:0] COLOR_RESET = 4'd15;

    // index of the last extra pixel in thick mode
    localparam logic [1:0] THICK_LAST = 2'd3;
    localparam logic [1:0] THIN_LAST  = 2'd0;

    localparam logic OP_START   = 1'b0;
    localparam logic OP_ADVANCE = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_XGO,
        ST_XDIV,
        ST_YDIV,
        ST_EMIT
    } ddalr_state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } ddalr_div_stat_t;

endpackage

// File: design/ddalr_div.sv
// ----------------------------------------------------------------------------
// ddalr_div
// Restoring divider, one quotient bit per cycle:
// quot = (mag * 2^FRAC_BITS + divisor / 2) / divisor, with mag <= divisor.
// ----------------------------------------------------------------------------
`include "dda_line_rasterizer_assert.svh"

module ddalr_div
    import ddalr_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [COORD_BITS-1:0] mag,
    input  logic [COORD_BITS-1:0] divisor,
    output logic [FRAC_BITS:0]    quot,
    output ddalr_div_stat_t       stat
);

    localparam int NW = COORD_BITS + FRAC_BITS + 1;
    localparam int CW = $clog2(FRAC_BITS + 1);
    localparam logic [CW-1:0] CNT_LAST = CW'(FRAC_BITS);

    logic [NW-1:0]         num;
    logic [COORD_BITS-1:0] rem_reg, rem_next;
    logic [FRAC_BITS:0]    work_reg, work_next;
    logic [CW-1:0]         cnt_reg, cnt_next;
    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [COORD_BITS:0]   trial;
    logic [COORD_BITS:0]   diff;
    logic                  ge;

    // numerator with the rounding half of the divisor folded in
    assign num   = {1'b0, mag, {FRAC_BITS{1'b0}}} + NW'(divisor >> 1);
    assign trial = {rem_reg, work_reg[FRAC_BITS]};
    assign diff  = trial - {1'b0, divisor};
    assign ge    = trial >= {1'b0, divisor};

    always_comb
    begin
        rem_next  = rem_reg;
        work_next = work_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            // top bits are already below the divisor, so F+1 steps suffice
            rem_next  = num[NW-1:FRAC_BITS+1];
            work_next = num[FRAC_BITS:0];
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next  = ge ? diff[COORD_BITS-1:0] : trial[COORD_BITS-1:0];
            work_next = {work_reg[FRAC_BITS-1:0], ge};
            cnt_next  = cnt_reg + 1'b1;
            if (cnt_reg == CNT_LAST)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        work_reg <= work_next;
    end

    assign quot      = work_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

    `DDALR_ASSERT(a_start_busy, start |=> busy_reg, "divider did not go busy on start")
    `DDALR_ASSERT(a_done_idle, done_reg |-> !busy_reg, "divider done while still busy")
    `DDALR_ASSERT(a_last_done, (busy_reg && !start && cnt_reg == CNT_LAST) |=> done_reg,
        "divider missed done after last step")

endmodule

// File: design/dda_line_rasterizer.sv
// ----------------------------------------------------------------------------
// dda_line_rasterizer
// DDA line rasterizer: start items set up a line, advance items emit pixels.
// ----------------------------------------------------------------------------
// One item at a time. For a start item, both increments go through one shared
// restoring divider that yields one quotient bit per cycle (FRAC_BITS+1 bits
// each), x first, then y: the item is accepted, the x division is launched,
// and each division ends with a done strobe. An advance item is accepted and
// then emits one pixel thin or four thick, each as the output takes it; an
// advance with no active line emits nothing. Pixel coordinates are the
// accumulators rounded to nearest; thick lines add x+1..x+3 on each row.
`include "dda_line_rasterizer_assert.svh"

module dda_line_rasterizer
    import ddalr_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [COLOR_W-1:0]    cfg_data,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  op,
    input  logic [COORD_BITS-1:0] x_start,
    input  logic [COORD_BITS-1:0] y_start,
    input  logic [COORD_BITS-1:0] x_end,
    input  logic [COORD_BITS-1:0] y_end,
    input  logic                  thick,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [COORD_BITS:0]   px,
    output logic [COORD_BITS-1:0] py,
    output logic [COLOR_W-1:0]    color,
    output logic                  run_last,
    output logic                  line_last
);

    localparam int AW = COORD_BITS + FRAC_BITS + 1;
    localparam int IW = FRAC_BITS + 2;

    ddalr_state_t state_reg, state_next;

    logic [COLOR_W-1:0]    color_reg, color_next;
    logic [COORD_BITS:0]   left_reg, left_next;
    logic                  thick_reg, thick_next;
    logic [1:0]            k_reg, k_next;
    logic signed [AW-1:0]  acc_x_reg, acc_x_next;
    logic signed [AW-1:0]  acc_y_reg, acc_y_next;
    logic signed [IW-1:0]  inc_x_reg, inc_x_next;
    logic signed [IW-1:0]  inc_y_reg, inc_y_next;
    logic [COORD_BITS-1:0] mag_x_reg, mag_x_next;
    logic [COORD_BITS-1:0] mag_y_reg, mag_y_next;
    logic                  neg_x_reg, neg_x_next;
    logic                  neg_y_reg, neg_y_next;
    logic [COORD_BITS-1:0] step_reg, step_next;

    logic                  in_acc;
    logic                  out_acc;
    logic                  neg_x, neg_y;
    logic [COORD_BITS-1:0] mag_x, mag_y;
    logic [1:0]            k_last;
    logic [COORD_BITS-1:0] cx, cy;

    logic                  div_start;
    logic [COORD_BITS-1:0] div_mag;
    logic [FRAC_BITS:0]    div_quot;
    ddalr_div_stat_t       div_stat;
    logic signed [IW-1:0]  inc_new;
    logic                  inc_neg;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = (state_reg == ST_EMIT);
    assign in_acc    = in_valid && in_ready;
    assign out_acc   = out_valid && out_ready;

    assign neg_x = x_end < x_start;
    assign neg_y = y_end < y_start;
    assign mag_x = neg_x ? (x_start - x_end) : (x_end - x_start);
    assign mag_y = neg_y ? (y_start - y_end) : (y_end - y_start);

    // x divides on entry, y starts as soon as x is done
    assign div_start = (state_reg == ST_XGO) || (state_reg == ST_XDIV && div_stat.done);
    assign div_mag   = (state_reg == ST_XGO) ? mag_x_reg : mag_y_reg;
    assign inc_neg   = (state_reg == ST_XDIV) ? neg_x_reg : neg_y_reg;

    // zero-length line: force a zero increment
    always_comb
    begin
        if (step_reg == '0)
            inc_new = '0;
        else if (inc_neg)
            inc_new = -$signed({1'b0, div_quot});
        else
            inc_new = $signed({1'b0, div_quot});
    end

    ddalr_div #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (div_start),
        .mag     (div_mag),
        .divisor (step_reg),
        .quot    (div_quot),
        .stat    (div_stat)
    );

    assign k_last = thick_reg ? THICK_LAST : THIN_LAST;
    // clamp negative positions to zero
    assign cx = acc_x_reg[AW-1] ? '0 : acc_x_reg[AW-2:FRAC_BITS];
    assign cy = acc_y_reg[AW-1] ? '0 : acc_y_reg[AW-2:FRAC_BITS];

    assign px        = {1'b0, cx} + {{(COORD_BITS-1){1'b0}}, k_reg};
    assign py        = cy;
    assign color     = color_reg;
    assign run_last  = (k_reg == k_last);
    assign line_last = (left_reg == {{COORD_BITS{1'b0}}, 1'b1});

    always_comb
    begin
        state_next = state_reg;
        color_next = color_reg;
        left_next  = left_reg;
        thick_next = thick_reg;
        k_next     = k_reg;
        acc_x_next = acc_x_reg;
        acc_y_next = acc_y_reg;
        inc_x_next = inc_x_reg;
        inc_y_next = inc_y_reg;
        mag_x_next = mag_x_reg;
        mag_y_next = mag_y_reg;
        neg_x_next = neg_x_reg;
        neg_y_next = neg_y_reg;
        step_next  = step_reg;

        if (cfg_we)
            color_next = cfg_data;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    if (op == OP_START)
                    begin
                        mag_x_next = mag_x;
                        mag_y_next = mag_y;
                        neg_x_next = neg_x;
                        neg_y_next = neg_y;
                        step_next  = (mag_x > mag_y) ? mag_x : mag_y;
                        left_next  = {1'b0, ((mag_x > mag_y) ? mag_x : mag_y)} + 1'b1;
                        thick_next = thick;
                        acc_x_next = $signed({1'b0, x_start, 1'b1, {(FRAC_BITS-1){1'b0}}});
                        acc_y_next = $signed({1'b0, y_start, 1'b1, {(FRAC_BITS-1){1'b0}}});
                        state_next = ST_XGO;
                    end
                    else if (left_reg != '0)
                    begin
                        k_next     = '0;
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_XGO:
            begin
                state_next = ST_XDIV;
            end
            ST_XDIV:
            begin
                if (div_stat.done)
                begin
                    inc_x_next = inc_new;
                    state_next = ST_YDIV;
                end
            end
            ST_YDIV:
            begin
                if (div_stat.done)
                begin
                    inc_y_next = inc_new;
                    state_next = ST_IDLE;
                end
            end
            ST_EMIT:
            begin
                if (out_acc)
                begin
                    if (k_reg == k_last)
                    begin
                        left_next = left_reg - 1'b1;
                        // hold the end point once the line is done
                        if (!line_last)
                        begin
                            acc_x_next = acc_x_reg + AW'(inc_x_reg);
                            acc_y_next = acc_y_reg + AW'(inc_y_reg);
                        end
                        k_next     = '0;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        k_next = k_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            color_reg <= COLOR_RESET;
            left_reg  <= '0;
            thick_reg <= 1'b0;
            k_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            color_reg <= color_next;
            left_reg  <= left_next;
            thick_reg <= thick_next;
            k_reg     <= k_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_x_reg <= acc_x_next;
        acc_y_reg <= acc_y_next;
        inc_x_reg <= inc_x_next;
        inc_y_reg <= inc_y_next;
        mag_x_reg <= mag_x_next;
        mag_y_reg <= mag_y_next;
        neg_x_reg <= neg_x_next;
        neg_y_reg <= neg_y_next;
        step_reg  <= step_next;
    end

    `DDALR_ASSERT(a_one_side, !(in_ready && out_valid), "input and output open together")
    `DDALR_ASSERT(a_run_end, (out_acc && run_last) |=> in_ready,
        "block not ready after last pixel of an advance")
    `DDALR_ASSERT(a_emit_line, out_valid |-> (left_reg != '0), "pixel emitted with no active line")
    `DDALR_ASSERT(a_idle_div, in_ready |-> !div_stat.busy, "ready while divider still busy")

endmodule

// File: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the DDA line rasterizer. It sends start and advance
// items through a valid/ready driver with random bursts and gaps, and applies
// random stalls on the pixel output. A built-in line model predicts every
// pixel, and each pixel is checked against it in arrival order. The pixel
// color is changed between phases while the block is idle.
// ----------------------------------------------------------------------------
module testbench
    import ddalr_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CW = COORD_BITS_DEF;
    localparam int FW = FRAC_BITS_DEF;
    localparam int COORD_MAX = (1 << CW) - 1;
    localparam int DRAIN_CYCLES = 60;

    typedef struct packed {
        logic          op;
        logic [CW-1:0] x_start;
        logic [CW-1:0] y_start;
        logic [CW-1:0] x_end;
        logic [CW-1:0] y_end;
        logic          thick;
    } line_item_t;

    typedef struct packed {
        logic [CW:0]        px;
        logic [CW-1:0]      py;
        logic [COLOR_W-1:0] color;
        logic               run_last;
        logic               line_last;
    } pixel_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_we = 1'b0;
    logic [COLOR_W-1:0] cfg_data = '0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic               op = OP_START;
    logic [CW-1:0]      x_start = '0;
    logic [CW-1:0]      y_start = '0;
    logic [CW-1:0]      x_end = '0;
    logic [CW-1:0]      y_end = '0;
    logic               thick = 1'b0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [CW:0]        px;
    logic [CW-1:0]      py;
    logic [COLOR_W-1:0] color;
    logic               run_last;
    logic               line_last;

    line_item_t pending_items[$];
    pixel_t     expected_pixels[$];
    int         errors = 0;
    int         queued = 0;

    // line model state
    logic [CW+FW:0]       pos_x = '0;
    logic [CW+FW:0]       pos_y = '0;
    logic signed [FW+1:0] step_x = '0;
    logic signed [FW+1:0] step_y = '0;
    logic [CW:0]          pix_remaining = '0;
    logic                 wide_line = 1'b0;
    logic [COLOR_W-1:0]   shade = COLOR_RESET;

    dda_line_rasterizer u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .op        (op),
        .x_start   (x_start),
        .y_start   (y_start),
        .x_end     (x_end),
        .y_end     (y_end),
        .thick     (thick),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .px        (px),
        .py        (py),
        .color     (color),
        .run_last  (run_last),
        .line_last (line_last)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    initial
    begin
        #4_000_000;
        $display("simulation failed");
        $finish;
    end

    // Fixed-point increment d/span, magnitude rounded half away from zero.
    function automatic logic signed [FW+1:0] slope_incr(int d, int span);
        int mag;
        int q;
        mag = (d < 0) ? -d : d;
        if (span == 0)
            return '0;
        q = ((mag << FW) + span / 2) / span;
        return (d < 0) ? -((FW+2)'(q)) : (FW+2)'(q);
    endfunction

    task automatic rasterize_item(line_item_t it);
        int     dx;
        int     dy;
        int     span;
        int     last;
        pixel_t pix;
        if (it.op == OP_START)
        begin
            dx = int'(it.x_end) - int'(it.x_start);
            dy = int'(it.y_end) - int'(it.y_start);
            span = ((dx < 0) ? -dx : dx) > ((dy < 0) ? -dy : dy) ?
                   ((dx < 0) ? -dx : dx) : ((dy < 0) ? -dy : dy);
            pos_x = ((CW+FW+1)'(it.x_start) << FW) | ((CW+FW+1)'(1) << (FW - 1));
            pos_y = ((CW+FW+1)'(it.y_start) << FW) | ((CW+FW+1)'(1) << (FW - 1));
            step_x = slope_incr(dx, span);
            step_y = slope_incr(dy, span);
            pix_remaining = (CW+1)'(span + 1);
            wide_line = it.thick;
        end
        else if (pix_remaining != 0)
        begin
            pix_remaining = pix_remaining - 1'b1;
            last = wide_line ? int'(THICK_LAST) : int'(THIN_LAST);
            for (int k = 0; k <= last; k++)
            begin
                pix.px = pos_x[FW+CW:FW] + (CW+1)'(k);
                pix.py = pos_y[FW+CW-1:FW];
                pix.color = shade;
                pix.run_last = (k == last);
                pix.line_last = (pix_remaining == 0);
                expected_pixels.push_back(pix);
            end
            if (pix_remaining != 0)
            begin
                pos_x = pos_x + {{(CW-1){step_x[FW+1]}}, step_x};
                pos_y = pos_y + {{(CW-1){step_y[FW+1]}}, step_y};
            end
        end
    endtask

    // Driver: bursts of items with random gaps in between.
    int gap_left = 0;
    int burst_left = 0;

    always @(posedge clk)
    begin
        line_item_t nxt;
        if (in_valid && in_ready)
            rasterize_item('{op, x_start, y_start, x_end, y_end, thick});
        if (!in_valid || in_ready)
        begin
            if (gap_left > 0 || pending_items.size() == 0)
            begin
                if (gap_left > 0)
                    gap_left--;
                in_valid <= 1'b0;
            end
            else
            begin
                nxt = pending_items.pop_front();
                op <= nxt.op;
                x_start <= nxt.x_start;
                y_start <= nxt.y_start;
                x_end <= nxt.x_end;
                y_end <= nxt.y_end;
                thick <= nxt.thick;
                in_valid <= 1'b1;
                if (burst_left > 0)
                    burst_left--;
                else
                begin
                    burst_left = $urandom_range(0, 15);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
            end
        end
    end

    // Output stalls: one of four stall patterns, picked again at random at intervals.
    int stall_tick = 0;
    int stall_mode = 0;

    always @(posedge clk)
    begin
        stall_tick++;
        if (stall_tick % 97 == 0)
            stall_mode = $urandom_range(0, 3);
        case (stall_mode)
            0: out_ready <= 1'b1;
            1: out_ready <= 1'($urandom_range(0, 1));
            2: out_ready <= (stall_tick % 5 == 0);
            default: out_ready <= ($urandom_range(0, 9) != 0);
        endcase
    end

    always @(posedge clk)
    begin
        pixel_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_pixels.size() == 0)
            begin
                $display("%0t: pixel with none expected: px=%0d py=%0d", $time, px, py);
                errors++;
            end
            else
            begin
                want = expected_pixels.pop_front();
                if (px !== want.px)
                begin
                    $display("%0t: px expected %0d actual %0d", $time, want.px, px);
                    errors++;
                end
                if (py !== want.py)
                begin
                    $display("%0t: py expected %0d actual %0d", $time, want.py, py);
                    errors++;
                end
                if (color !== want.color)
                begin
                    $display("%0t: color expected %0d actual %0d", $time, want.color, color);
                    errors++;
                end
                if (run_last !== want.run_last)
                begin
                    $display("%0t: run_last expected %0b actual %0b", $time,
                             want.run_last, run_last);
                    errors++;
                end
                if (line_last !== want.line_last)
                begin
                    $display("%0t: line_last expected %0b actual %0b", $time,
                             want.line_last, line_last);
                    errors++;
                end
            end
        end
    end

    task automatic push_item(logic o, int xs, int ys, int xe, int ye, logic t);
        line_item_t it;
        it.op = o;
        it.x_start = CW'(xs);
        it.y_start = CW'(ys);
        it.x_end = CW'(xe);
        it.y_end = CW'(ye);
        it.thick = t;
        pending_items.push_back(it);
        queued++;
    endtask

    // Advance items carry random coordinates, which the block ignores.
    task automatic push_advances(int n);
        repeat (n)
            push_item(OP_ADVANCE, $urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX),
                      $urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX),
                      1'($urandom_range(0, 1)));
    endtask

    task automatic push_line(int xs, int ys, int xe, int ye, logic t, int n);
        push_item(OP_START, xs, ys, xe, ye, t);
        push_advances(n);
    endtask

    // Hold until every item is sent and every pixel has come, then let a
    // possible start item finish its division.
    task automatic drain();
        int waited;
        waited = 0;
        while (pending_items.size() != 0 || in_valid)
            @(negedge clk);
        while (expected_pixels.size() != 0 && waited < 20000)
        begin
            @(negedge clk);
            waited++;
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_color(logic [COLOR_W-1:0] v);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        shade = v;
    endtask

    function automatic int clamp_coord(int v);
        return (v < 0) ? 0 : ((v > COORD_MAX) ? COORD_MAX : v);
    endfunction

    initial
    begin
        int xs;
        int ys;
        int xe;
        int ye;
        int sel;
        int span;
        int steps;
        int target;
        logic [COLOR_W-1:0] phase_color[5];
        phase_color = '{COLOR_RESET, 4'd0, 4'($urandom_range(1, 14)), 4'd15,
                        4'($urandom_range(0, 15))};
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Directed lines: no active line, single-pixel lines at both corners,
        // long lines dropped by a new start, and negative slopes.
        push_advances(1);
        push_line(0, 0, 0, 0, 1'b0, 2);
        push_line(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, 1'b1, 1);
        push_line(COORD_MAX, 0, COORD_MAX - 3, COORD_MAX, 1'b1, 2);
        push_line(0, COORD_MAX, COORD_MAX, 0, 1'b0, 2);
        push_line(5, 5, 2, 7, 1'b0, 4);
        push_line(10, 3, 10, 0, 1'b1, 4);

        for (int phase = 0; phase < 5; phase++)
        begin
            // the first phase runs with the reset color
            if (phase != 0)
                write_color(phase_color[phase]);
            target = queued + 42;
            while (queued < target)
            begin
                sel = $urandom_range(0, 9);
                xs = (sel == 0) ? $urandom_range(0, 1) * COORD_MAX : $urandom_range(0, COORD_MAX);
                ys = (sel == 1) ? $urandom_range(0, 1) * COORD_MAX : $urandom_range(0, COORD_MAX);
                span = ($urandom_range(0, 7) == 0) ? 40 : 10;
                xe = clamp_coord(xs + $urandom_range(0, 2 * span) - span);
                ye = clamp_coord(ys + $urandom_range(0, 2 * span) - span);
                steps = ((xe > xs) ? xe - xs : xs - xe) > ((ye > ys) ? ye - ys : ys - ye) ?
                        ((xe > xs) ? xe - xs : xs - xe) : ((ye > ys) ? ye - ys : ys - ye);
                if (sel < 8)
                    push_line(xs, ys, xe, ye, 1'($urandom_range(0, 1)),
                              steps + 1 + (($urandom_range(0, 3) == 0) ? 1 : 0));
                else if (sel == 8)
                    push_line(xs, ys, $urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX),
                              1'($urandom_range(0, 1)), $urandom_range(0, 6));
                else
                    push_advances($urandom_range(1, 3));
            end
            drain();
        end

        if (errors == 0 && expected_pixels.size() == 0)
            $display("simulation ok");
        else
        begin
            if (expected_pixels.size() != 0)
                $display("%0t: %0d expected pixels never came", $time, expected_pixels.size());
            $display("simulation failed");
        end
        $finish;
    end

endmodule
